@@ rtl/core/rc_satellite_frame_decoder_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef RC_SATELLITE_FRAME_DECODER_MACROS_SVH
`define RC_SATELLITE_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, off during reset.
`define RCSFD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, off during reset.
`define RCSFD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Check that holds on the edge right after a reset cycle.
`define RCSFD_ASSERT_POST_RST(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) $past(rst) |-> (cons)) \
    else $error("%m: post-reset check failed");

`endif

@@ rtl/core/rcsfd_pkg.sv @@
package rcsfd_pkg;

  localparam int FRAME_BYTES     = 16;
  localparam int WORDS_PER_FRAME = 7;
  localparam int HDR_BYTES       = 2;
  localparam int BYTE_AW         = $clog2(FRAME_BYTES);
  localparam int RAM_AW          = BYTE_AW + 1;
  localparam int WORD_IW         = $clog2(WORDS_PER_FRAME);
  localparam int JOB_DEPTH       = 2;
  localparam int JOB_PW          = $clog2(JOB_DEPTH);
  localparam int JOB_CW          = $clog2(JOB_DEPTH + 1);

  localparam logic [7:0] HDR_A = 8'h03;
  localparam logic [7:0] HDR_B = 8'hB2;

  localparam logic [1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [1:0] MODE_TEN     = 2'd1;
  localparam logic [1:0] MODE_ELEVEN  = 2'd2;

  localparam logic FMT_TEN    = 1'b0;
  localparam logic FMT_ELEVEN = 1'b1;

  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;
  localparam int GAP_W    = 16;
  localparam int DETECT_W = 4;

  localparam logic [CFG_IW-1:0] REG_GAP_LIMIT     = 2'd0;
  localparam logic [CFG_IW-1:0] REG_DETECT_FRAMES = 2'd1;

  localparam logic [GAP_W-1:0]    GAP_LIMIT_RST = 16'd150;
  localparam logic [DETECT_W-1:0] DETECT_RST    = 4'd10;

  typedef struct packed {
    logic        bank;
    logic        fmt;
    logic [31:0] interval;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } job_push_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
  } ram_rd_t;

endpackage

@@ rtl/core/rcsfd_if.sv @@
interface rcsfd_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] arrival_time_us;

  modport source(output valid, rx_byte, arrival_time_us, input ready);
  modport sink(input valid, rx_byte, arrival_time_us, output ready);
  modport mon(input valid, ready, rx_byte, arrival_time_us);
endinterface

interface rcsfd_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel_index;
  logic signed [10:0] channel_value;
  logic               word_format;
  logic [31:0]        frame_interval_us;
  logic               last_of_frame;

  modport source(output valid, channel_index, channel_value, word_format,
                 frame_interval_us, last_of_frame, input ready);
  modport sink(input valid, channel_index, channel_value, word_format,
               frame_interval_us, last_of_frame, output ready);
  modport mon(input valid, ready, channel_index, channel_value, word_format,
              frame_interval_us, last_of_frame);
endinterface

interface rcsfd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rcsfd_pkg::CFG_IW-1:0]    index;
  logic [rcsfd_pkg::CFG_DW-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
  modport mon(input valid, ready, index, data);
endinterface

@@ rtl/core/rc_satellite_frame_decoder.sv @@
// A decoded frame's last byte queues its job; the back reads each channel word in S_HI
// and S_LO and registers its result in S_CAP. Throughput: one byte per cycle while the
// frame queue has room; frames unpack word by word via the frame RAM's single read port.
// Input stalls only while two decoded frames are pending in the job queue.
// Reset: synchronous, active high; clears all control state and restores the
// gap limit (150 us) and detect count (10). Frame RAM contents are not cleared.
module rc_satellite_frame_decoder (
  input  logic           clk,
  input  logic           rst,
  rcsfd_byte_if.sink     rx,
  rcsfd_result_if.source res,
  rcsfd_cfg_if.sink      cfg
);

  // Front/back handoff. The frame RAM has two banks: the front fills one
  // while the back unpacks the other. A job in the queue owns its bank
  // until the back loads the frame's last word into the result register.
  rcsfd_pkg::ram_wr_t    ram_wr;
  rcsfd_pkg::ram_rd_t    ram_rd;
  logic [7:0]            ram_rd_data;
  rcsfd_pkg::job_push_t  job_push;
  rcsfd_pkg::job_t       job_head;
  rcsfd_pkg::fifo_stat_t job_stat;
  logic                  job_pop;

  // Front: gap check, byte store, header tally, format detection, and
  // per-frame interval stamping. Frames with no results never reach the queue.
  rcsfd_front u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .cfg  (cfg),
    .stat (job_stat),
    .wr   (ram_wr),
    .push (job_push)
  );

  // Two-entry queue of completed frames to unpack.
  rcsfd_job_fifo u_job_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .pop  (job_pop),
    .head (job_head),
    .stat (job_stat)
  );

  // Two banks of frame bytes.
  rcsfd_frame_ram u_frame_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_rd_data)
  );

  // Back: read each channel word as two bytes, decode, and drive the
  // result register; advance only when the result slot frees up.
  rcsfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (job_head),
    .stat    (job_stat),
    .pop     (job_pop),
    .rd      (ram_rd),
    .rd_data (ram_rd_data),
    .res     (res)
  );

endmodule

@@ rtl/core/rcsfd_frame_ram.sv @@
module rcsfd_frame_ram (
  input  logic               clk,
  input  rcsfd_pkg::ram_wr_t wr,
  input  rcsfd_pkg::ram_rd_t rd,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [2*rcsfd_pkg::FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

@@ rtl/core/rcsfd_job_fifo.sv @@
module rcsfd_job_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  rcsfd_pkg::job_push_t  push,
  input  logic                  pop,
  output rcsfd_pkg::job_t       head,
  output rcsfd_pkg::fifo_stat_t stat
);

  rcsfd_pkg::job_t                 entries [rcsfd_pkg::JOB_DEPTH];
  logic [rcsfd_pkg::JOB_PW-1:0]    wr_ptr;
  logic [rcsfd_pkg::JOB_PW-1:0]    rd_ptr;
  logic [rcsfd_pkg::JOB_CW-1:0]    count;

  assign head           = entries[rd_ptr];
  assign stat.not_empty = (count != '0);
  assign stat.full      = (count == rcsfd_pkg::JOB_CW'(rcsfd_pkg::JOB_DEPTH));

  always_ff @(posedge clk) begin
    if (push.push) begin
      entries[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/rcsfd_front.sv @@
module rcsfd_front (
  input  logic                  clk,
  input  logic                  rst,
  rcsfd_byte_if.sink            rx,
  rcsfd_cfg_if.sink             cfg,
  input  rcsfd_pkg::fifo_stat_t stat,
  output rcsfd_pkg::ram_wr_t    wr,
  output rcsfd_pkg::job_push_t  push
);

  logic [rcsfd_pkg::GAP_W-1:0]    gap_limit;
  logic [rcsfd_pkg::DETECT_W-1:0] detect_frames;

  logic [rcsfd_pkg::BYTE_AW-1:0]  byte_count;
  logic [31:0]                    last_byte_time;
  logic [31:0]                    last_frame_time;
  logic [1:0]                     format_mode;
  logic [rcsfd_pkg::DETECT_W-1:0] frames_to_wait;
  logic [15:0]                    count_ten;
  logic [15:0]                    count_eleven;
  logic                           wbank;
  logic [7:0]                     hdr0;
  logic [7:0]                     hdr1;

  logic                           take;
  logic [31:0]                    gap;
  logic                           gap_bad;
  logic [rcsfd_pkg::BYTE_AW-1:0]  pos;
  logic                           complete;
  logic                           hdr_ok;
  logic                           decode_ok;
  logic [15:0]                    ten_next;
  logic [15:0]                    eleven_next;
  logic                           ten_wins;
  logic                           eleven_wins;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit     <= rcsfd_pkg::GAP_LIMIT_RST;
      detect_frames <= rcsfd_pkg::DETECT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        rcsfd_pkg::REG_GAP_LIMIT: begin
          gap_limit <= cfg.data[rcsfd_pkg::GAP_W-1:0];
        end
        rcsfd_pkg::REG_DETECT_FRAMES: begin
          detect_frames <= cfg.data[rcsfd_pkg::DETECT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Hold input while both frame banks are owned by queued jobs.
  assign rx.ready = !stat.full;
  assign take     = rx.valid && rx.ready;

  assign gap      = rx.arrival_time_us - last_byte_time;
  assign gap_bad  = (byte_count != '0) && (gap > {16'd0, gap_limit});
  assign pos      = gap_bad ? '0 : byte_count;
  assign complete = (pos == rcsfd_pkg::BYTE_AW'(rcsfd_pkg::FRAME_BYTES - 1));
  assign hdr_ok   = (hdr0 == rcsfd_pkg::HDR_A) && (hdr1 == rcsfd_pkg::HDR_B);
  assign decode_ok = (format_mode != rcsfd_pkg::MODE_UNKNOWN) &&
                     !((format_mode == rcsfd_pkg::MODE_TEN) && !hdr_ok);

  assign wr.en   = take;
  assign wr.addr = {wbank, pos};
  assign wr.data = rx.rx_byte;

  assign push.push         = take && complete && decode_ok;
  assign push.job.bank     = wbank;
  assign push.job.fmt      = (format_mode == rcsfd_pkg::MODE_ELEVEN) ?
                             rcsfd_pkg::FMT_ELEVEN : rcsfd_pkg::FMT_TEN;
  assign push.job.interval = rx.arrival_time_us - last_frame_time;

  // Saturating header tallies and the two-to-one majority test.
  always_comb begin
    ten_next    = count_ten;
    eleven_next = count_eleven;
    if (hdr_ok) begin
      if (count_ten != 16'hFFFF) begin
        ten_next = count_ten + 16'd1;
      end
    end else begin
      if (count_eleven != 16'hFFFF) begin
        eleven_next = count_eleven + 16'd1;
      end
    end
    ten_wins    = {2'b00, ten_next} > {1'b0, eleven_next, 1'b0};
    eleven_wins = {2'b00, eleven_next} > {1'b0, ten_next, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (take && (pos == rcsfd_pkg::BYTE_AW'(0))) begin
      hdr0 <= rx.rx_byte;
    end
    if (take && (pos == rcsfd_pkg::BYTE_AW'(1))) begin
      hdr1 <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      last_byte_time  <= '0;
      last_frame_time <= '0;
      format_mode     <= rcsfd_pkg::MODE_UNKNOWN;
      frames_to_wait  <= rcsfd_pkg::DETECT_RST;
      count_ten       <= '0;
      count_eleven    <= '0;
      wbank           <= 1'b0;
    end else if (take) begin
      last_byte_time <= rx.arrival_time_us;
      byte_count     <= complete ? '0 : pos + 1'b1;
      if (complete) begin
        if (format_mode == rcsfd_pkg::MODE_UNKNOWN) begin
          count_ten    <= ten_next;
          count_eleven <= eleven_next;
          if (frames_to_wait != '0) begin
            frames_to_wait <= frames_to_wait - 1'b1;
          end else if (ten_wins) begin
            format_mode <= rcsfd_pkg::MODE_TEN;
          end else if (eleven_wins) begin
            format_mode <= rcsfd_pkg::MODE_ELEVEN;
          end else begin
            frames_to_wait <= detect_frames;
          end
        end else if (decode_ok) begin
          last_frame_time <= rx.arrival_time_us;
          wbank           <= ~wbank;
        end
      end
    end
  end

endmodule

@@ rtl/core/rcsfd_back.sv @@
module rcsfd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rcsfd_pkg::job_t       head,
  input  rcsfd_pkg::fifo_stat_t stat,
  output logic                  pop,
  output rcsfd_pkg::ram_rd_t    rd,
  input  logic [7:0]            rd_data,
  rcsfd_result_if.source        res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HI   = 2'd1;
  localparam logic [1:0] S_LO   = 2'd2;
  localparam logic [1:0] S_CAP  = 2'd3;

  localparam logic [9:0]  TEN_CENTER    = 10'd512;
  localparam logic [10:0] ELEVEN_CENTER = 11'd1024;

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic [rcsfd_pkg::WORD_IW-1:0] word_idx;
  logic [7:0]                    hi_byte;

  logic                          out_valid;
  logic [3:0]                    out_index;
  logic [10:0]                   out_value;
  logic                          out_format;
  logic [31:0]                   out_interval;
  logic                          out_last;

  logic [rcsfd_pkg::BYTE_AW-1:0] hi_addr;
  logic [15:0]                   word;
  logic [9:0]                    ten_val;
  logic [3:0]                    dec_index;
  logic [10:0]                   dec_value;
  logic                          last_word;
  logic                          load_word;

  assign hi_addr = rcsfd_pkg::BYTE_AW'({word_idx, 1'b0}) +
                   rcsfd_pkg::BYTE_AW'(rcsfd_pkg::HDR_BYTES);

  assign rd.en   = (state == S_HI) || (state == S_LO);
  assign rd.addr = {head.bank, (state == S_HI) ? hi_addr : (hi_addr + 1'b1)};

  assign word    = {hi_byte, rd_data};
  assign ten_val = word[9:0] - TEN_CENTER;

  always_comb begin
    if (head.fmt == rcsfd_pkg::FMT_TEN) begin
      dec_index = word[13:10];
      dec_value = {ten_val, 1'b0};
    end else begin
      dec_index = word[14:11];
      dec_value = word[10:0] - ELEVEN_CENTER;
    end
  end

  assign last_word = (word_idx == rcsfd_pkg::WORD_IW'(rcsfd_pkg::WORDS_PER_FRAME - 1));
  assign load_word = (state == S_CAP) && (!out_valid || res.ready);
  assign pop       = load_word && last_word;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (stat.not_empty) begin
          state_next = S_HI;
        end
      end
      S_HI: begin
        state_next = S_LO;
      end
      S_LO: begin
        state_next = S_CAP;
      end
      S_CAP: begin
        if (load_word) begin
          state_next = last_word ? S_IDLE : S_HI;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      word_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        word_idx <= '0;
      end else if (load_word) begin
        word_idx <= word_idx + 1'b1;
      end
      if (load_word) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LO) begin
      hi_byte <= rd_data;
    end
    if (load_word) begin
      out_index    <= dec_index;
      out_value    <= dec_value;
      out_format   <= head.fmt;
      out_interval <= head.interval;
      out_last     <= last_word;
    end
  end

  assign res.valid             = out_valid;
  assign res.channel_index     = out_index;
  assign res.channel_value     = signed'(out_value);
  assign res.word_format       = out_format;
  assign res.frame_interval_us = out_interval;
  assign res.last_of_frame     = out_last;

endmodule

@@ rtl/core/rcsfd_checker.sv @@
`include "rc_satellite_frame_decoder_macros.svh"

module rcsfd_checker (
  input logic              clk,
  input logic              rst,
  rcsfd_byte_if.sink       rx,
  rcsfd_result_if.source   res,
  rcsfd_cfg_if.sink        cfg
);

  // A stalled result keeps its value.
  `RCSFD_ASSERT_NXT(a_res_hold, clk, rst, res.valid && !res.ready, res.valid && $stable(res.channel_value) && $stable(res.channel_index) && $stable(res.frame_interval_us))

  // Ten-bit words are scaled by two, so their values are always even.
  `RCSFD_ASSERT_IMP(a_ten_bit_even, clk, rst, res.valid && (res.word_format == 1'b0), res.channel_value[0] == 1'b0)

  // The job queue is empty after reset, so bytes are taken at once.
  `RCSFD_ASSERT_POST_RST(a_ready_after_rst, clk, rst, rx.ready)

  // Register writes are never held off.
  `RCSFD_ASSERT_IMP(a_cfg_ready, clk, rst, cfg.valid, cfg.ready)

endmodule

bind rc_satellite_frame_decoder rcsfd_checker u_rcsfd_checker (
  .clk (clk),
  .rst (rst),
  .rx  (rx),
  .res (res),
  .cfg (cfg)
);

@@ test/testbench.sv @@
module testbench;
  import rcsfd_pkg::*;

  // Index that decodes to no register; writes to it must leave the block alone.
  localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

  localparam int QUIET_LIMIT   = 3000;  // cycles with no transaction before giving up
  localparam int SETTLE_CYCLES = 40;    // settle time after the drain, for frames that make no result
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;   // long receiver stall, fills the job queue
  localparam int HOLD_FRAMES   = 3;     // good frames offered during the stall
  localparam int DECODE_BYTES  = 96;    // random section queues at least this many bytes
  localparam int DETECT_FRAMES = 13;    // complete frames sent while the format is unknown

  typedef struct packed {
    logic [3:0]         idx;
    logic signed [10:0] value;
    logic               fmt;
    logic [31:0]        interval;
    logic               last;
  } chan_result_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] stamp;
  } rx_item_t;

  class frame_decoder_sb;
    logic [7:0]   frame_buf [FRAME_BYTES];
    logic [4:0]   fill;
    logic [31:0]  prev_byte_t;
    logic [31:0]  prev_frame_t;
    logic [1:0]   mode;
    logic [3:0]   wait_left;
    logic [15:0]  ten_hits;
    logic [15:0]  eleven_hits;
    logic [15:0]  gap_limit;
    logic [3:0]   detect_reload;
    chan_result_t pending_channels[$];
    int           errors;

    function new();
      fill          = '0;
      prev_byte_t   = '0;
      prev_frame_t  = '0;
      mode          = MODE_UNKNOWN;
      wait_left     = DETECT_RST;
      ten_hits      = '0;
      eleven_hits   = '0;
      gap_limit     = GAP_LIMIT_RST;
      detect_reload = DETECT_RST;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_GAP_LIMIT:     gap_limit = data[GAP_W-1:0];
        REG_DETECT_FRAMES: detect_reload = data[DETECT_W-1:0];
        default: ;
      endcase
    endfunction

    // Vote on the header, then either count down or try to settle the format.
    function void classify_header();
      logic ten_hdr;
      ten_hdr = (frame_buf[0] == HDR_A) && (frame_buf[1] == HDR_B);
      if (ten_hdr) begin
        if (ten_hits != 16'hFFFF) ten_hits++;
      end else if (eleven_hits != 16'hFFFF) begin
        eleven_hits++;
      end
      if (wait_left != 0)
        wait_left--;
      else if ({2'b00, ten_hits} > {1'b0, eleven_hits, 1'b0})
        mode = MODE_TEN;
      else if ({2'b00, eleven_hits} > {1'b0, ten_hits, 1'b0})
        mode = MODE_ELEVEN;
      else
        wait_left = detect_reload;
    endfunction

    function void unpack_frame(logic [31:0] now);
      chan_result_t r;
      logic [15:0]  w;
      if (mode == MODE_TEN && (frame_buf[0] != HDR_A || frame_buf[1] != HDR_B)) return;
      r.interval   = now - prev_frame_t;
      prev_frame_t = now;
      for (int k = 0; k < WORDS_PER_FRAME; k++) begin
        w = {frame_buf[2 + 2 * k], frame_buf[3 + 2 * k]};
        if (mode == MODE_TEN) begin
          r.idx   = w[13:10];
          r.value = {w[9:0] - 10'd512, 1'b0};
          r.fmt   = FMT_TEN;
        end else begin
          r.idx   = w[14:11];
          r.value = w[10:0] - 11'd1024;
          r.fmt   = FMT_ELEVEN;
        end
        r.last = (k == WORDS_PER_FRAME - 1);
        pending_channels.push_back(r);
      end
    endfunction

    function void note_byte(logic [7:0] data, logic [31:0] stamp);
      logic [31:0] gap;
      gap         = stamp - prev_byte_t;
      prev_byte_t = stamp;
      if (fill != 0 && gap > {16'h0, gap_limit}) fill = '0;
      frame_buf[fill[3:0]] = data;
      fill++;
      if (fill == FRAME_BYTES) begin
        if (mode == MODE_UNKNOWN) classify_header();
        else unpack_frame(stamp);
        fill = '0;
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_channel(chan_result_t got);
      chan_result_t want;
      if (pending_channels.size() == 0) begin
        report($sformatf("unexpected channel %0d value %0d", got.idx, got.value));
        return;
      end
      want = pending_channels.pop_front();
      if (got.idx !== want.idx)
        report($sformatf("channel index %0d, want %0d", got.idx, want.idx));
      if (got.value !== want.value)
        report($sformatf("channel value %0d, want %0d", got.value, want.value));
      if (got.fmt !== want.fmt)
        report($sformatf("word format %0b, want %0b", got.fmt, want.fmt));
      if (got.interval !== want.interval)
        report($sformatf("frame interval %0d, want %0d", got.interval, want.interval));
      if (got.last !== want.last)
        report($sformatf("last of frame %0b, want %0b", got.last, want.last));
    endtask

    task flush();
      if (pending_channels.size() != 0)
        report($sformatf("%0d channel results never arrived", pending_channels.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  rcsfd_byte_if   rx();
  rcsfd_result_if res();
  rcsfd_cfg_if    cfg();

  rc_satellite_frame_decoder u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res),
    .cfg (cfg)
  );

  frame_decoder_sb sb;
  rx_item_t        byte_q[$];
  rx_item_t        tx_item;
  chan_result_t    seen_chan;
  int              rx_queued;
  int              rx_taken;
  int              src_idle_pct;
  int              sink_idle_pct;
  int              quiet;
  logic            hold_off;
  bit              hold_go;
  logic [31:0]     now_us;   // timestamp of the last queued byte
  bit              target_ten;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Byte sender: load the next byte only once the current one has gone through,
  // and skip cycles at random to leave gaps on the input.
  always @(posedge clk) begin
    if (rst) begin
      rx.valid           <= 1'b0;
      rx.rx_byte         <= '0;
      rx.arrival_time_us <= '0;
    end else if (!rx.valid || rx.ready) begin
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        tx_item            = byte_q.pop_front();
        rx.valid           <= 1'b1;
        rx.rx_byte         <= tx_item.data;
        rx.arrival_time_us <= tx_item.stamp;
      end else begin
        rx.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure, plus the long hold-off when asked.
  always @(posedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= !hold_off && ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Hold the result side for a long stretch while bytes keep coming, so the
  // job queue fills and the block has to stall its input.
  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Monitor: predict on every accepted byte, check every accepted result.
  always @(posedge clk) begin
    if (!rst && rx.valid && rx.ready) begin
      sb.note_byte(rx.rx_byte, rx.arrival_time_us);
      rx_taken++;
    end
    if (!rst && res.valid && res.ready) begin
      seen_chan.idx      = res.channel_index;
      seen_chan.value    = res.channel_value;
      seen_chan.fmt      = res.word_format;
      seen_chan.interval = res.frame_interval_us;
      seen_chan.last     = res.last_of_frame;
      sb.check_channel(seen_chan);
    end
  end

  // Watchdog: end the run when no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Wait until every queued byte is taken and every predicted channel has come
  // out, then give a frame that makes no result time to finish in the block.
  task automatic wait_quiet();
    int n = 0;
    while ((rx_taken != rx_queued || sb.pending_channels.size() != 0) && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function void push_byte(logic [7:0] data, logic [31:0] dt);
    rx_item_t it;
    now_us   = now_us + dt;
    it.data  = data;
    it.stamp = now_us;
    byte_q.push_back(it);
    rx_queued++;
  endfunction

  // Gap that keeps the current frame going.
  function logic [31:0] inner_gap();
    case ($urandom_range(0, 7))
      0:       return {16'h0, sb.gap_limit};
      1:       return 32'd0;
      default: return $urandom_range(0, sb.gap_limit);
    endcase
  endfunction

  // Gap that drops whatever partial frame is in the block.
  function logic [31:0] late_gap();
    if ($urandom_range(0, 1) == 0) return {16'h0, sb.gap_limit} + 32'd1;
    return {16'h0, sb.gap_limit} + 32'd1 + $urandom_range(0, 1000);
  endfunction

  function void pick_header(bit ten, output logic [7:0] hdr0, output logic [7:0] hdr1);
    if (ten) begin
      hdr0 = HDR_A;
      hdr1 = HDR_B;
      return;
    end
    case ($urandom_range(0, 3))
      0:       begin hdr0 = HDR_A;         hdr1 = 8'($urandom); end
      1:       begin hdr0 = 8'($urandom);  hdr1 = HDR_B;        end
      default: begin hdr0 = 8'($urandom);  hdr1 = 8'($urandom); end
    endcase
    if (hdr0 == HDR_A && hdr1 == HDR_B) hdr1 = ~HDR_B;
  endfunction

  // One complete frame. resync: arrive late so a partial frame before is dropped.
  // at_limit: each gap at the limit bar a resync's first. fill_byte < 0: random payload.
  function void queue_frame(logic [7:0] hdr0, logic [7:0] hdr1, bit resync,
                            int fill_byte = -1, bit at_limit = 1'b0);
    logic [31:0] first_dt;
    if (resync) first_dt = late_gap();
    else if (at_limit) first_dt = {16'h0, sb.gap_limit};
    else if ($urandom_range(0, 3) == 0) first_dt = $urandom;
    else first_dt = inner_gap();
    push_byte(hdr0, first_dt);
    push_byte(hdr1, at_limit ? {16'h0, sb.gap_limit} : inner_gap());
    for (int i = HDR_BYTES; i < FRAME_BYTES; i++)
      push_byte((fill_byte < 0) ? 8'($urandom) : 8'(fill_byte),
                at_limit ? {16'h0, sb.gap_limit} : inner_gap());
  endfunction

  // Partial frame; the caller must resync the next frame.
  function void queue_fragment();
    int count;
    count = $urandom_range(1, FRAME_BYTES - 1);
    push_byte(($urandom_range(0, 1) == 0) ? HDR_A : 8'($urandom), inner_gap());
    for (int i = 1; i < count; i++) push_byte(8'($urandom), inner_gap());
  endfunction

  function void queue_random_frame();
    logic [7:0] h0;
    logic [7:0] h1;
    bit         resync;
    resync = 1'b0;
    if ($urandom_range(0, 4) == 0) begin
      queue_fragment();
      resync = 1'b1;
    end
    // Mostly good headers; in the 10-bit format a bad one must be dropped.
    if (target_ten) pick_header($urandom_range(0, 5) != 0, h0, h1);
    else pick_header($urandom_range(0, 5) == 0, h0, h1);
    queue_frame(h0, h1, resync);
  endfunction

  initial begin
    logic [15:0] cfg_word;
    logic [7:0]  h0;
    logic [7:0]  h1;
    bit          other;
    bit          resync;
    int          base;

    rst                = 1'b1;
    cfg.valid          = 1'b0;
    cfg.index          = '0;
    cfg.data           = '0;
    hold_go            = 1'b0;
    src_idle_pct       = 35;
    sink_idle_pct      = 56;
    rx_queued          = 0;
    now_us             = '0;
    sb                 = new();
    target_ten         = $urandom_range(0, 1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Format detection. The reload value only matters on an inconclusive vote,
    // so load zero now; every vote after the first comes one frame later.
    cfg_word      = 16'($urandom);
    cfg_word[3:0] = 4'h0;
    write_reg(REG_DETECT_FRAMES, cfg_word);
    write_reg(REG_UNUSED, 16'($urandom));

    // Eleven frames with four against: inconclusive, reload with zero. The
    // twelfth leaves the vote at exactly twice, still no decision, and the
    // thirteenth decides.
    for (int n = 1; n <= DETECT_FRAMES; n++) begin
      other = (n <= 11) && ((n == 1) || (n % 3 == 0));
      resync = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        queue_fragment();
        resync = 1'b1;
      end
      pick_header(other ? !target_ten : target_ten, h0, h1);
      queue_frame(h0, h1, resync);
    end
    wait_quiet();

    // Swap the idle mix for the directed part.
    src_idle_pct  <= 56;
    sink_idle_pct <= 35;

    // Directed frames at the reset gap limit: payload extremes, gaps exactly at
    // the limit across the 32-bit time wrap, near-miss headers, a dropped partial.
    pick_header(1'b1, h0, h1);
    queue_frame(h0, h1, 1'b0, 8'h00);
    queue_frame(h0, h1, 1'b0, 8'hFF);
    now_us = 32'hFFFF_FF00;
    queue_frame(h0, h1, 1'b0, -1, 1'b1);
    queue_frame(HDR_A, 8'h00, 1'b0);
    queue_frame(8'h00, HDR_B, 1'b0);
    push_byte(HDR_A, inner_gap());
    push_byte(HDR_B, inner_gap());
    queue_frame(h0, h1, 1'b1, 8'h02);
    wait_quiet();

    // Smallest gap limit: only equal timestamps keep a frame together.
    write_reg(REG_GAP_LIMIT, 16'd0);
    queue_frame(h0, h1, 1'b0, -1, 1'b1);
    queue_fragment();
    queue_frame(h0, h1, 1'b1, -1, 1'b1);
    wait_quiet();

    write_reg(REG_GAP_LIMIT, 16'hFFFF);
    queue_frame(h0, h1, 1'b0, -1, 1'b1);
    queue_fragment();
    queue_frame(h0, h1, 1'b1);
    wait_quiet();
    write_reg(REG_GAP_LIMIT, GAP_LIMIT_RST);

    // Random frames with neither side idling: hold the receiver off at the start
    // while good frames keep coming, and change the gap limit now and then while idle.
    src_idle_pct  <= 0;
    sink_idle_pct <= 0;
    base    = rx_queued;
    hold_go = 1'b1;
    for (int i = 0; i < HOLD_FRAMES; i++) queue_frame(HDR_A, HDR_B, 1'b0);
    while (rx_queued - base < DECODE_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        wait_quiet();
        case ($urandom_range(0, 3))
          0:       write_reg(REG_GAP_LIMIT, 16'd0);
          1:       write_reg(REG_GAP_LIMIT, 16'hFFFF);
          2:       write_reg(REG_GAP_LIMIT, GAP_LIMIT_RST);
          default: write_reg(REG_GAP_LIMIT, 16'($urandom_range(1, 400)));
        endcase
        if ($urandom_range(0, 1) == 0) write_reg(REG_DETECT_FRAMES, 16'($urandom));
        else write_reg(REG_UNUSED, 16'($urandom));
      end
      queue_random_frame();
    end

    wait_quiet();
    sb.flush();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
